>>> hw/rtl/max_heap_priority_queue_core_assert.svh
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core_assert
// assertion macros shared by the checker, sampled on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define MHPQ_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MHPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// types, constants and command codes of the max-heap priority queue
// ----------------------------------------------------------------------------
package mhpq_pkg;

   localparam int CAPACITY = 128;
   localparam int KEY_W    = 32;
   localparam int COUNT_W  = 8;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int IDX_W    = $clog2(CAPACITY + 1);
   localparam int CHILD_W  = IDX_W + 1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_REMOVE = 1'b1;

   typedef struct packed {
      logic                    action;
      logic signed [KEY_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic signed [KEY_W-1:0] removed_value;
      logic signed [KEY_W-1:0] top_value;
      logic [COUNT_W-1:0]      entry_count;
   } rsp_type;

   typedef struct packed {
      logic ins_start;
      logic rej_full;
      logic rej_empty;
      logic rem_start;
      logic rem_last;
      logic up_read;
      logic up_move;
      logic dn_read;
      logic dn_move;
      logic wr_key;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic at_root;
      logic no_child;
      logic move_up;
      logic move_down;
   } dp_status_type;

endpackage

>>> hw/rtl/mhpq_ram.sv
// ----------------------------------------------------------------------------
// mhpq_ram
// generic ram: one write port, two read ports, registered read data
// ----------------------------------------------------------------------------
module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr_b,
   output logic [WIDTH-1:0]           rd_data_a,
   output logic [WIDTH-1:0]           rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> hw/rtl/mhpq_ctrl.sv
// ----------------------------------------------------------------------------
// mhpq_ctrl
// sequencer for insert and remove: sift up, sift down, result hand-off
// ----------------------------------------------------------------------------
module mhpq_ctrl import mhpq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_action,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type dp_status,
   output cmd_type       cmd
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_REM_LAST = 7'b0000010,
      ST_UP_RD    = 7'b0000100,
      ST_UP_CMP   = 7'b0001000,
      ST_DN_RD    = 7'b0010000,
      ST_DN_CMP   = 7'b0100000,
      ST_FINISH   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action == ACTION_INSERT) begin
                  if (dp_status.full) begin
                     cmd.rej_full = 1'b1;
                     state_in     = ST_FINISH;
                  end else begin
                     cmd.ins_start = 1'b1;
                     state_in      = ST_UP_RD;
                  end
               end else begin
                  if (dp_status.empty) begin
                     cmd.rej_empty = 1'b1;
                     state_in      = ST_FINISH;
                  end else begin
                     cmd.rem_start = 1'b1;
                     state_in      = ST_REM_LAST;
                  end
               end
            end
         end
         ST_REM_LAST: begin
            // last entry now in hand; nothing to sift if the heap went empty
            cmd.rem_last = 1'b1;
            state_in     = dp_status.empty ? ST_FINISH : ST_DN_RD;
         end
         ST_UP_RD: begin
            if (dp_status.at_root) begin
               cmd.wr_key = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               cmd.up_read = 1'b1;
               state_in    = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (dp_status.move_up) begin
               cmd.up_move = 1'b1;
               state_in    = ST_UP_RD;
            end else begin
               cmd.wr_key = 1'b1;
               state_in   = ST_FINISH;
            end
         end
         ST_DN_RD: begin
            if (dp_status.no_child) begin
               cmd.wr_key = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               cmd.dn_read = 1'b1;
               state_in    = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            if (dp_status.move_down) begin
               cmd.dn_move = 1'b1;
               state_in    = ST_DN_RD;
            end else begin
               cmd.wr_key = 1'b1;
               state_in   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/mhpq_datapath.sv
// ----------------------------------------------------------------------------
// mhpq_datapath
// heap store, sift index, moving key, count, root copy and result register
// ----------------------------------------------------------------------------
module mhpq_datapath import mhpq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req,
   input  cmd_type       cmd,
   output dp_status_type dp_status,
   output rsp_type       rsp
);

   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [IDX_W-1:0]        count_ff, count_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic signed [KEY_W-1:0] top_ff, top_in;
   logic signed [KEY_W-1:0] removed_ff, removed_in;
   logic [1:0]              status_ff, status_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [IDX_W-1:0]   parent_idx;
   logic [IDX_W-1:0]   idx_m1;
   logic [CHILD_W-1:0] left_idx;
   logic [CHILD_W-1:0] right_idx;
   logic [CHILD_W-1:0] count_ext;
   logic [CHILD_W-1:0] rd_idx;
   logic [CHILD_W-1:0] rd_m1;
   logic               pick_right;
   logic [KEY_W-1:0]   pick_data;
   logic [IDX_W-1:0]   pick_idx;

   logic               wr_en;
   logic [KEY_W-1:0]   wr_data;
   logic [KEY_W-1:0]   rd_data_a;
   logic [KEY_W-1:0]   rd_data_b;

   assign parent_idx = idx_ff >> 1;
   assign idx_m1     = idx_ff - IDX_W'(1);
   assign left_idx   = {idx_ff, 1'b0};
   assign right_idx  = {idx_ff, 1'b1};
   assign count_ext  = {1'b0, count_ff};

   // port a serves the last entry, the parent or the left child; port b the right child
   always_comb begin
      if (cmd.rem_start) begin
         rd_idx = count_ext;
      end else if (cmd.up_read) begin
         rd_idx = {1'b0, parent_idx};
      end else begin
         rd_idx = left_idx;
      end
   end
   assign rd_m1 = rd_idx - CHILD_W'(1);

   // left child wins ties
   assign pick_right = (right_idx <= count_ext) &&
                       ($signed(rd_data_b) > $signed(rd_data_a));
   assign pick_data  = pick_right ? rd_data_b : rd_data_a;
   assign pick_idx   = pick_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];

   assign wr_en   = cmd.wr_key || cmd.up_move || cmd.dn_move;
   assign wr_data = cmd.wr_key  ? key_ff :
                    cmd.up_move ? rd_data_a : pick_data;

   mhpq_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (idx_m1[ADDR_W-1:0]),
      .wr_data   (wr_data),
      .rd_addr_a (rd_m1[ADDR_W-1:0]),
      .rd_addr_b (left_idx[ADDR_W-1:0]),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   always_comb begin
      dp_status.full      = (count_ff == IDX_W'(CAPACITY));
      dp_status.empty     = (count_ff == '0);
      dp_status.at_root   = (idx_ff == IDX_W'(1));
      dp_status.no_child  = (left_idx > count_ext);
      dp_status.move_up   = ($signed(rd_data_a) < key_ff);
      dp_status.move_down = ($signed(pick_data) > key_ff);
   end

   always_comb begin
      idx_in     = idx_ff;
      count_in   = count_ff;
      key_in     = key_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      rsp_in     = rsp_ff;
      // root copy follows every write to the first slot
      top_in     = (wr_en && dp_status.at_root) ? $signed(wr_data) : top_ff;

      if (cmd.ins_start) begin
         key_in     = req.value;
         count_in   = count_ff + IDX_W'(1);
         idx_in     = count_ff + IDX_W'(1);
         status_in  = STATUS_OK;
         removed_in = '0;
      end
      if (cmd.rej_full) begin
         status_in  = STATUS_FULL;
         removed_in = '0;
      end
      if (cmd.rej_empty) begin
         status_in  = STATUS_EMPTY;
         removed_in = '0;
      end
      if (cmd.rem_start) begin
         removed_in = top_ff;
         status_in  = STATUS_OK;
         count_in   = count_ff - IDX_W'(1);
      end
      if (cmd.rem_last) begin
         key_in = $signed(rd_data_a);
         idx_in = IDX_W'(1);
      end
      if (cmd.up_move) begin
         idx_in = parent_idx;
      end
      if (cmd.dn_move) begin
         idx_in = pick_idx;
      end
      if (cmd.rsp_load) begin
         rsp_in.status        = status_ff;
         rsp_in.removed_value = removed_ff;
         rsp_in.top_value     = (count_ff == '0) ? '0 : top_ff;
         rsp_in.entry_count   = COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      key_ff     <= key_in;
      top_ff     <= top_in;
      removed_ff <= removed_in;
      status_ff  <= status_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule

>>> hw/rtl/max_heap_priority_queue_core.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core
// binary max-heap priority queue of signed 32-bit keys, 128 entries
// ----------------------------------------------------------------------------
// req_ carries one transaction: action 0 inserts value, action 1 removes the
// maximum. rsp_ returns exactly one transaction per request with the status,
// the removed key, the new top key and the entry count.
// A transaction is taken on a rising edge with valid high and stall low.
// One request is worked at a time; req_stall stays high until its result
// sits in the output register. Each heap level takes a ram read, then a
// compare and move: an insert climbs from the new last slot and stops at
// the root or below a parent that is not smaller; a remove moves the last
// key to the root and descends while a child is larger than it, and skips
// the sift when it takes the last key. Rejected requests skip the heap.
// A waiting result does not block the next request; it holds its payload
// while rsp_stall is high, and the next result waits behind it.
// Reset empties the heap and drops any pending result; no clearing pass.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_core import mhpq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   cmd_type       cmd;
   dp_status_type dp_status;

   mhpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req.action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .dp_status  (dp_status),
      .cmd        (cmd)
   );

   mhpq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .dp_status (dp_status),
      .rsp       (rsp)
   );

endmodule

>>> hw/rtl/mhpq_checker.sv
// ----------------------------------------------------------------------------
// mhpq_checker
// port-level checks on the result channel of the heap queue
// ----------------------------------------------------------------------------
`include "max_heap_priority_queue_core_assert.svh"

module mhpq_checker import mhpq_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp
);

   `MHPQ_ASSERT_NEXT(a_rsp_valid_hold, rsp_valid && rsp_stall, rsp_valid,
      "rsp_valid dropped while stalled")

   `MHPQ_ASSERT_NEXT(a_rsp_payload_hold, rsp_valid && rsp_stall, $stable(rsp),
      "rsp payload changed while stalled")

   `MHPQ_ASSERT_IMPLY(a_empty_top_zero, rsp_valid && (rsp.entry_count == '0),
      rsp.top_value == '0, "empty heap reports a non-zero top")

   `MHPQ_ASSERT_IMPLY(a_reject_no_removal,
      rsp_valid && (rsp.status == STATUS_FULL || rsp.status == STATUS_EMPTY),
      rsp.removed_value == '0, "rejected transaction reports a removed key")

endmodule

bind max_heap_priority_queue_core mhpq_checker u_checker (.*);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the max-heap priority queue: inserts and removals
// are scored against a heap kept alongside the design, with random gaps on
// both channels and a stretch of back-to-back traffic
// ----------------------------------------------------------------------------
module tb_top;
   import mhpq_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 6;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;

   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   // shadow heap, 1-based like the design
   logic signed [KEY_W-1:0] heap_keys [1:CAPACITY];
   int                      heap_size    = 0;
   rsp_type                 pending_rsps [$];

   int error_count  = 0;
   int quiet_cycles = 0;
   int req_idle_pct = 35;
   int rsp_idle_pct = 35;

   max_heap_priority_queue_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   task automatic report_mismatch(input string detail);
      $display("[%0t] ERROR: %s", $time, detail);
      error_count++;
   endtask

   function automatic void swap_keys(input int a, input int b);
      logic signed [KEY_W-1:0] held;
      held         = heap_keys[a];
      heap_keys[a] = heap_keys[b];
      heap_keys[b] = held;
   endfunction

   // applies one transaction to the shadow heap and returns the result it owes
   function automatic rsp_type predict_heap_step(input req_type item);
      rsp_type outcome;
      int      slot;
      int      child;
      outcome        = '0;
      outcome.status = STATUS_OK;
      if (item.action == ACTION_INSERT) begin
         if (heap_size >= CAPACITY) begin
            outcome.status = STATUS_FULL;
         end else begin
            heap_size++;
            slot            = heap_size;
            heap_keys[slot] = item.value;
            // climb only past a strictly smaller parent
            while (slot > 1 && heap_keys[slot / 2] < heap_keys[slot]) begin
               swap_keys(slot / 2, slot);
               slot = slot / 2;
            end
         end
      end else if (heap_size == 0) begin
         outcome.status = STATUS_EMPTY;
      end else begin
         outcome.removed_value = heap_keys[1];
         heap_keys[1]          = heap_keys[heap_size];
         heap_size--;
         slot = 1;
         while (2 * slot <= heap_size) begin
            child = 2 * slot;
            // left child wins a tie
            if (child + 1 <= heap_size && heap_keys[child + 1] > heap_keys[child])
               child++;
            if (heap_keys[child] <= heap_keys[slot])
               break;
            swap_keys(child, slot);
            slot = child;
         end
      end
      outcome.top_value   = (heap_size > 0) ? heap_keys[1] : '0;
      outcome.entry_count = COUNT_W'(heap_size);
      return outcome;
   endfunction

   function automatic logic signed [KEY_W-1:0] random_key();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0:       return KEY_MIN;
               1:       return KEY_MAX;
               2:       return '0;
               default: return '1;
            endcase
         end
         // narrow range gives plenty of equal keys
         1, 2, 3: return KEY_W'(int'($urandom_range(0, 15)) - 8);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(input logic action, input logic signed [KEY_W-1:0] key);
      req_type item;
      item.action = action;
      item.value  = key;
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req       <= item;
      do @(posedge clock); while (req_stall);
      pending_rsps.push_back(predict_heap_step(item));
   endtask

   task automatic test_directed_edges();
      send_item(ACTION_REMOVE, KEY_MAX);
      send_item(ACTION_INSERT, 32'sd5);
      send_item(ACTION_REMOVE, '0);
      send_item(ACTION_INSERT, KEY_MIN);
      send_item(ACTION_INSERT, KEY_MAX);
      send_item(ACTION_INSERT, '0);
      send_item(ACTION_INSERT, '1);
      send_item(ACTION_INSERT, 32'sd7);
      send_item(ACTION_INSERT, 32'sd7);
      send_item(ACTION_INSERT, 32'sd7);
      send_item(ACTION_INSERT, KEY_MAX);
      send_item(ACTION_INSERT, KEY_MIN);
      // value is a don't-care on removal
      repeat (9) send_item(ACTION_REMOVE, $urandom);
      send_item(ACTION_REMOVE, '1);
   endtask

   task automatic test_fill_and_overflow();
      while (heap_size < CAPACITY) send_item(ACTION_INSERT, random_key());
      repeat (3) send_item(ACTION_INSERT, random_key());
      while (heap_size > 0) send_item(ACTION_REMOVE, $urandom);
      repeat (2) send_item(ACTION_REMOVE, $urandom);
   endtask

   task automatic run_random_items(input int item_total, input int insert_pct);
      repeat (item_total) begin
         send_item(($urandom_range(0, 99) < insert_pct) ? ACTION_INSERT : ACTION_REMOVE,
                   random_key());
      end
   endtask

   task automatic test_random_mix();
      // swing the fill level so full and empty both come round again
      run_random_items(150, 85);
      run_random_items(150, 50);
      run_random_items(150, 15);
      run_random_items(150, 80);
      run_random_items(100, 25);
   endtask

   task automatic test_back_to_back();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random_items(170, 65);
      run_random_items(170, 35);
      req_idle_pct = 35;
      rsp_idle_pct = 35;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_rsps.size() == 0) begin
            report_mismatch($sformatf("unexpected result %p", rsp));
         end else begin
            want = pending_rsps.pop_front();
            if (rsp.status !== want.status)
               report_mismatch($sformatf("status got %0d expected %0d",
                                         rsp.status, want.status));
            if (rsp.removed_value !== want.removed_value)
               report_mismatch($sformatf("removed_value got %0d expected %0d",
                                         rsp.removed_value, want.removed_value));
            if (rsp.top_value !== want.top_value)
               report_mismatch($sformatf("top_value got %0d expected %0d",
                                         rsp.top_value, want.top_value));
            if (rsp.entry_count !== want.entry_count)
               report_mismatch($sformatf("entry_count got %0d expected %0d",
                                         rsp.entry_count, want.entry_count));
         end
      end
   end

   // gives up once no transaction has moved on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("max_heap_priority_queue_core regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      test_directed_edges();
      test_fill_and_overflow();
      test_random_mix();
      test_back_to_back();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("max_heap_priority_queue_core regression: pass");
      else
         $display("max_heap_priority_queue_core regression: fail");
      $finish;
   end

endmodule

>>> max_heap_priority_queue_core.f
+incdir+hw/rtl
hw/rtl/mhpq_pkg.sv
hw/rtl/mhpq_ram.sv
hw/rtl/mhpq_ctrl.sv
hw/rtl/mhpq_datapath.sv
hw/rtl/max_heap_priority_queue_core.sv
hw/rtl/mhpq_checker.sv
dv/tb_top.sv
